@@ hw/rtl/tef_pkg.sv @@
// Shared types and constants for the triangle edge-flip test core.
package tef_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int DET_WIDTH   = PROD_WIDTH + 1;
    localparam int TOL_WIDTH   = 20;
    localparam int COUNT_WIDTH = 4;
    localparam int LANES       = 4;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a0_x;
        logic signed [COORD_WIDTH-1:0] a0_y;
        logic signed [COORD_WIDTH-1:0] a1_x;
        logic signed [COORD_WIDTH-1:0] a1_y;
        logic signed [COORD_WIDTH-1:0] a2_x;
        logic signed [COORD_WIDTH-1:0] a2_y;
        logic signed [COORD_WIDTH-1:0] b0_x;
        logic signed [COORD_WIDTH-1:0] b0_y;
        logic signed [COORD_WIDTH-1:0] b1_x;
        logic signed [COORD_WIDTH-1:0] b1_y;
        logic signed [COORD_WIDTH-1:0] b2_x;
        logic signed [COORD_WIDTH-1:0] b2_y;
    } tef_item_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] shared_pairs;
        logic                   flippable;
        logic                   degenerate;
    } tef_result_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } tef_pt_t;

    // Per-stage advance enables for the determinant lanes.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } tef_adv_t;

endpackage

@@ hw/rtl/tef_select.sv @@
// Vertex matching stage: counts shared vertices and picks points a, b, c and d.
module tef_select (
    input  logic                         clk,
    input  logic                         en,
    input  tef_pkg::tef_item_t           item,
    output tef_pkg::tef_pt_t             pa,
    output tef_pkg::tef_pt_t             pb,
    output tef_pkg::tef_pt_t             pc,
    output tef_pkg::tef_pt_t             pd,
    output logic [tef_pkg::COUNT_WIDTH-1:0] count,
    output logic                         pair2
);

    tef_pkg::tef_pt_t ta [3];
    tef_pkg::tef_pt_t tb [3];
    logic             eq [3][3];
    logic             aa [3][3];
    logic [1:0]       ia;
    logic [1:0]       ib;
    logic             found;

    tef_pkg::tef_pt_t pa_reg, pa_next;
    tef_pkg::tef_pt_t pb_reg, pb_next;
    tef_pkg::tef_pt_t pc_reg, pc_next;
    tef_pkg::tef_pt_t pd_reg, pd_next;
    logic [tef_pkg::COUNT_WIDTH-1:0] count_reg, count_next;

    always_comb
    begin
        ta[0] = '{x: item.a0_x, y: item.a0_y};
        ta[1] = '{x: item.a1_x, y: item.a1_y};
        ta[2] = '{x: item.a2_x, y: item.a2_y};
        tb[0] = '{x: item.b0_x, y: item.b0_y};
        tb[1] = '{x: item.b1_x, y: item.b1_y};
        tb[2] = '{x: item.b2_x, y: item.b2_y};
    end

    always_comb
    begin
        count_next = '0;
        ia         = 2'd0;
        ib         = 2'd0;
        found      = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                eq[i][j]   = (ta[i] == tb[j]);
                aa[i][j]   = (i == j) || (ta[i] == ta[j]);
                count_next = count_next + tef_pkg::COUNT_WIDTH'(eq[i][j]);
            end
        end
        // The first matching pair gives a and the last gives b.
        for (int i = 0; i < 3; i++)
        begin
            if (eq[i][0] || eq[i][1] || eq[i][2])
            begin
                if (!found)
                begin
                    ia = 2'(i);
                end
                ib    = 2'(i);
                found = 1'b1;
            end
        end
        pa_next = ta[ia];
        pb_next = ta[ib];
        pc_next = '0;
        pd_next = '0;
        // The last vertex equal to neither a nor b is the lone vertex.
        for (int i = 0; i < 3; i++)
        begin
            if (!aa[i][ia] && !aa[i][ib])
            begin
                pc_next = ta[i];
            end
            if (!eq[ia][i] && !eq[ib][i])
            begin
                pd_next = tb[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            pc_reg    <= pc_next;
            pd_reg    <= pd_next;
            count_reg <= count_next;
        end
    end

    assign pa    = pa_reg;
    assign pb    = pb_reg;
    assign pc    = pc_reg;
    assign pd    = pd_reg;
    assign count = count_reg;
    assign pair2 = (count_reg == tef_pkg::COUNT_WIDTH'(2));

endmodule

@@ hw/rtl/tef_orient_lane.sv @@
// One orientation determinant lane: differences, products, determinant, flags.
module tef_orient_lane (
    input  logic                          clk,
    input  tef_pkg::tef_adv_t             adv,
    input  tef_pkg::tef_pt_t              p,
    input  tef_pkg::tef_pt_t              q,
    input  tef_pkg::tef_pt_t              r,
    input  logic [tef_pkg::TOL_WIDTH-1:0] tol,
    output logic                          small_det,
    output logic                          pos_det
);

    localparam int CW = tef_pkg::COORD_WIDTH;
    localparam int DW = tef_pkg::DIFF_WIDTH;
    localparam int PW = tef_pkg::PROD_WIDTH;
    localparam int TW = tef_pkg::DET_WIDTH;

    logic signed [DW-1:0] qx_reg, ry_reg, rx_reg, qy_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic signed [TW-1:0] det_reg, det_next;
    logic        [TW-1:0] mag;
    logic                 small_reg, small_next;
    logic                 pos_reg, pos_next;

    always_comb
    begin
        det_next   = TW'(p1_reg) - TW'(p2_reg);
        mag        = det_reg[TW-1] ? TW'(-det_reg) : TW'(det_reg);
        small_next = (mag <= TW'(tol));
        pos_next   = !det_reg[TW-1] && (det_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            qx_reg <= $signed({q.x[CW-1], q.x}) - $signed({p.x[CW-1], p.x});
            ry_reg <= $signed({r.y[CW-1], r.y}) - $signed({p.y[CW-1], p.y});
            rx_reg <= $signed({r.x[CW-1], r.x}) - $signed({p.x[CW-1], p.x});
            qy_reg <= $signed({q.y[CW-1], q.y}) - $signed({p.y[CW-1], p.y});
        end
        if (adv.s3)
        begin
            p1_reg <= PW'(qx_reg) * PW'(ry_reg);
            p2_reg <= PW'(rx_reg) * PW'(qy_reg);
        end
        if (adv.s4)
        begin
            det_reg <= det_next;
        end
        if (adv.s5)
        begin
            small_reg <= small_next;
            pos_reg   <= pos_next;
        end
    end

    assign small_det = small_reg;
    assign pos_det   = pos_reg;

endmodule

@@ hw/rtl/tef_merge.sv @@
// Merging stage: combines the lane flags into the registered result beat.
module tef_merge (
    input  logic                            clk,
    input  logic                            en,
    input  logic [tef_pkg::LANES-1:0]       small_det,
    input  logic [tef_pkg::LANES-1:0]       pos_det,
    input  logic [tef_pkg::COUNT_WIDTH-1:0] count,
    input  logic                            pair2,
    output tef_pkg::tef_result_t            result
);

    tef_pkg::tef_result_t result_reg, result_next;
    logic                 any_small;

    always_comb
    begin
        any_small                = |small_det;
        result_next.shared_pairs = count;
        result_next.degenerate   = pair2 && any_small;
        // Lanes 0 and 1 test c and d against line ab; lanes 2 and 3 test b and a
        // against line cd.
        result_next.flippable    = pair2 && !any_small
                                   && (pos_det[0] != pos_det[1])
                                   && (pos_det[2] != pos_det[3]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

@@ hw/rtl/triangle_edge_flip_test_core.sv @@
// Top level of the triangle edge-flip test core with pipeline control.
//
//   Channel  | Handshake               | Beat contents
//   ---------+-------------------------+-------------------------------------
//   item     | item_valid / item_stall | two triangles, three points each
//   result   | result_valid / result_stall | shared_pairs, flippable, degenerate
//   cfg      | cfg_valid / cfg_ready   | det_tolerance, 20 bits
//
// One item beat is accepted per cycle while item_stall is low; its result beat
// passes through the six-stage pipeline: vertex matching, four stages of each
// determinant lane (differences, products, determinant, tolerance compare)
// and the merging output register.
// Reset clears all stage valid bits and sets det_tolerance to zero.
// Each stage holds while the next one is full and cannot move, so a stalled
// result leaves the earlier stages free to fill their empty slots.
module triangle_edge_flip_test_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  tef_pkg::tef_item_t              item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output tef_pkg::tef_result_t            result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tef_pkg::TOL_WIDTH-1:0]   cfg_data
);

    localparam int CNT = tef_pkg::COUNT_WIDTH;

    // Stage valid bits, stage 1 (matching) through stage 6 (output register).
    logic [6:1] v_reg, v_next;
    logic [6:1] en;

    logic [tef_pkg::TOL_WIDTH-1:0] tol_reg;

    tef_pkg::tef_pt_t pa, pb, pc, pd;
    logic [CNT-1:0]   count1;
    logic             pair2_1;

    // The count and the two-shared flag travel alongside the lanes.
    logic [CNT-1:0] cnt_reg [2:5];
    logic           p2_reg  [2:5];

    tef_pkg::tef_adv_t           adv;
    logic [tef_pkg::LANES-1:0]   small_det;
    logic [tef_pkg::LANES-1:0]   pos_det;

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb
    begin
        en[6] = !v_reg[6] || !result_stall;
        for (int k = 5; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[1] = en[1] ? item_valid : v_reg[1];
        for (int k = 2; k <= 6; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    assign adv = '{s2: en[2], s3: en[3], s4: en[4], s5: en[5]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            tol_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
            if (cfg_valid && cfg_ready)
            begin
                tol_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            cnt_reg[2] <= count1;
            p2_reg[2]  <= pair2_1;
        end
        for (int k = 3; k <= 5; k++)
        begin
            if (en[k])
            begin
                cnt_reg[k] <= cnt_reg[k-1];
                p2_reg[k]  <= p2_reg[k-1];
            end
        end
    end

    tef_select u_select (
        .clk   (clk),
        .en    (en[1]),
        .item  (item),
        .pa    (pa),
        .pb    (pb),
        .pc    (pc),
        .pd    (pd),
        .count (count1),
        .pair2 (pair2_1)
    );

    // Lane 0: c against ab. Lane 1: d against ab.
    // Lane 2: b against cd. Lane 3: a against cd.
    tef_orient_lane u_lane0 (
        .clk (clk), .adv (adv), .p (pa), .q (pb), .r (pc), .tol (tol_reg),
        .small_det (small_det[0]), .pos_det (pos_det[0])
    );

    tef_orient_lane u_lane1 (
        .clk (clk), .adv (adv), .p (pa), .q (pb), .r (pd), .tol (tol_reg),
        .small_det (small_det[1]), .pos_det (pos_det[1])
    );

    tef_orient_lane u_lane2 (
        .clk (clk), .adv (adv), .p (pc), .q (pd), .r (pb), .tol (tol_reg),
        .small_det (small_det[2]), .pos_det (pos_det[2])
    );

    tef_orient_lane u_lane3 (
        .clk (clk), .adv (adv), .p (pc), .q (pd), .r (pa), .tol (tol_reg),
        .small_det (small_det[3]), .pos_det (pos_det[3])
    );

    tef_merge u_merge (
        .clk       (clk),
        .en        (en[6]),
        .small_det (small_det),
        .pos_det   (pos_det),
        .count     (cnt_reg[5]),
        .pair2     (p2_reg[5]),
        .result    (result)
    );

    assign item_stall   = !en[1];
    assign result_valid = v_reg[6];
    assign cfg_ready    = 1'b1;

`ifndef SYNTHESIS
    a_degen_not_flip: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.degenerate |-> !result.flippable)
        else $error("degenerate result also marked flippable");

    a_only_two_shared: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.shared_pairs != CNT'(2))
        |-> !result.flippable && !result.degenerate)
        else $error("flags set without exactly two shared vertices");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.shared_pairs <= CNT'(9)))
        else $error("shared vertex count out of range");

    a_stage5_moves: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[5] && en[6] |=> result_valid)
        else $error("item lost between last lane stage and output");
`endif

endmodule

@@ bench/tb_triangle_edge_flip_test_core.sv @@
// Self-checking testbench for the triangle edge-flip test core.
`timescale 1ns / 100ps

module tb_triangle_edge_flip_test_core;

    // The run is cut off here. A correct run needs far fewer cycles, even
    // with every beat waiting out the longest sender gap and receiver stall.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Cycles allowed after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 12;
    localparam logic [tef_pkg::TOL_WIDTH-1:0] TOL_MAX = '1;

    // Three points of one triangle, kept as a packed array.
    typedef tef_pkg::tef_pt_t [2:0] tri_pts_t;

    logic                          clk;
    logic                          rst_n;
    logic                          item_valid;
    logic                          item_stall;
    tef_pkg::tef_item_t            item;
    logic                          result_valid;
    logic                          result_stall;
    tef_pkg::tef_result_t          result;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [tef_pkg::TOL_WIDTH-1:0] cfg_data;

    // The tolerance that the core holds, as far as the bench knows.
    logic [tef_pkg::TOL_WIDTH-1:0] tol_now;
    // Verdicts predicted for accepted item beats, oldest first.
    tef_pkg::tef_result_t          pending_verdicts[$];
    int                            mismatches;
    int                            cycle_count;
    // While set, neither side inserts gaps or stalls.
    bit                            quiet;

    triangle_edge_flip_test_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Orientation of r against the directed line p->q. With 16-bit
    // coordinates the value always fits in 64 bits.
    function automatic longint orient(longint px, longint py, longint qx, longint qy,
                                      longint rx, longint ry);
        return (qx - px) * (ry - py) - (rx - px) * (qy - py);
    endfunction

    // Expected verdict for one pair of triangles under tolerance tol.
    function automatic tef_pkg::tef_result_t predict_verdict(
        tef_pkg::tef_item_t it, logic [tef_pkg::TOL_WIDTH-1:0] tol);
        longint               tx[6];
        longint               ty[6];
        longint               ax, ay, bx, by, cx, cy, dx, dy;
        longint               det[4];
        longint               mag;
        longint               tol_l;
        int unsigned          hits;
        bit                   have_a, degen, flip;
        int                   i, j, k;
        tef_pkg::tef_result_t res;
        // Entries 0..2 are the first triangle, 3..5 the second one.
        tx[0] = longint'(it.a0_x); ty[0] = longint'(it.a0_y);
        tx[1] = longint'(it.a1_x); ty[1] = longint'(it.a1_y);
        tx[2] = longint'(it.a2_x); ty[2] = longint'(it.a2_y);
        tx[3] = longint'(it.b0_x); ty[3] = longint'(it.b0_y);
        tx[4] = longint'(it.b1_x); ty[4] = longint'(it.b1_y);
        tx[5] = longint'(it.b2_x); ty[5] = longint'(it.b2_y);
        ax = 0; ay = 0; bx = 0; by = 0; cx = 0; cy = 0; dx = 0; dy = 0;
        hits = 0;
        have_a = 1'b0;
        degen = 1'b0;
        flip = 1'b0;
        tol_l = longint'(tol);
        // The first equal pair in scan order names a, the last names b.
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
                if (tx[i] == tx[3 + j] && ty[i] == ty[3 + j])
                begin
                    hits++;
                    if (!have_a)
                    begin
                        ax = tx[i];
                        ay = ty[i];
                        have_a = 1'b1;
                    end
                    else
                    begin
                        bx = tx[i];
                        by = ty[i];
                    end
                end
        if (hits == 2)
        begin
            // The lone vertices are the last ones equal to neither a nor b.
            for (i = 0; i < 3; i++)
            begin
                if (!(tx[i] == ax && ty[i] == ay) && !(tx[i] == bx && ty[i] == by))
                begin
                    cx = tx[i];
                    cy = ty[i];
                end
                if (!(tx[3 + i] == ax && ty[3 + i] == ay) &&
                    !(tx[3 + i] == bx && ty[3 + i] == by))
                begin
                    dx = tx[3 + i];
                    dy = ty[3 + i];
                end
            end
            det[0] = orient(ax, ay, bx, by, cx, cy);
            det[1] = orient(ax, ay, bx, by, dx, dy);
            det[2] = orient(cx, cy, dx, dy, bx, by);
            det[3] = orient(cx, cy, dx, dy, ax, ay);
            for (k = 0; k < 4; k++)
            begin
                mag = (det[k] < 0) ? -det[k] : det[k];
                if (mag <= tol_l)
                    degen = 1'b1;
            end
            if (!degen)
                flip = ((det[0] > 0) != (det[1] > 0)) && ((det[2] > 0) != (det[3] > 0));
        end
        res.shared_pairs = hits[tef_pkg::COUNT_WIDTH-1:0];
        res.flippable    = flip;
        res.degenerate   = degen;
        return res;
    endfunction

    function automatic tef_pkg::tef_pt_t pt(int x, int y);
        tef_pkg::tef_pt_t p;
        p.x = x[tef_pkg::COORD_WIDTH-1:0];
        p.y = y[tef_pkg::COORD_WIDTH-1:0];
        return p;
    endfunction

    function automatic tef_pkg::tef_item_t make_pair(
        tef_pkg::tef_pt_t p0, tef_pkg::tef_pt_t p1, tef_pkg::tef_pt_t p2,
        tef_pkg::tef_pt_t q0, tef_pkg::tef_pt_t q1, tef_pkg::tef_pt_t q2);
        tef_pkg::tef_item_t it;
        it.a0_x = p0.x; it.a0_y = p0.y;
        it.a1_x = p1.x; it.a1_y = p1.y;
        it.a2_x = p2.x; it.a2_y = p2.y;
        it.b0_x = q0.x; it.b0_y = q0.y;
        it.b1_x = q1.x; it.b1_y = q1.y;
        it.b2_x = q2.x; it.b2_y = q2.y;
        return it;
    endfunction

    // Coordinate ranges: 0 full, 1 narrow, 2 medium, 3 extreme values,
    // 4 a three-value grid where points coincide often.
    function automatic int rand_coord(int unsigned mode);
        logic [tef_pkg::COORD_WIDTH-1:0] raw;
        int                              picks[5];
        picks = '{-32768, -1, 0, 1, 32767};
        raw = tef_pkg::COORD_WIDTH'($urandom);
        case (mode)
            1: return int'($urandom_range(0, 16)) - 8;
            2: return int'($urandom_range(0, 2048)) - 1024;
            3: return picks[$urandom_range(0, 4)];
            4: return int'($urandom_range(0, 2)) - 1;
            default: return int'($signed(raw));
        endcase
    endfunction

    function automatic tef_pkg::tef_pt_t rand_pt(int unsigned mode);
        return pt(rand_coord(mode), rand_coord(mode));
    endfunction

    function automatic tri_pts_t shuffled(tri_pts_t v);
        tef_pkg::tef_pt_t t;
        int unsigned      j;
        for (int k = 2; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            t = v[k];
            v[k] = v[j];
            v[j] = t;
        end
        return v;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Sends one item beat and records its verdict once the beat is taken.
    // Valid stays high into the next beat when no gap follows.
    task automatic push_pair(tef_pkg::tef_item_t it);
        int unsigned gap;
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        pending_verdicts.push_back(predict_verdict(it, tol_now));
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits until every predicted verdict has come back, then waits out SETTLE_CYCLES.
    task automatic drain();
        item_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only with the pipeline empty.
    task automatic set_tolerance(logic [tef_pkg::TOL_WIDTH-1:0] value);
        drain();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        tol_now = value;
        cfg_valid <= 1'b0;
    endtask

    // Coordinates at both ends of the range, including a maximal convex square.
    task automatic test_extremes();
        tef_pkg::tef_pt_t lo, hi, lohi, hilo;
        lo   = pt(-32768, -32768);
        hi   = pt(32767, 32767);
        lohi = pt(-32768, 32767);
        hilo = pt(32767, -32768);
        push_pair(make_pair(lo, lo, lo, lo, lo, lo));
        push_pair(make_pair(hi, hi, hi, hi, hi, hi));
        push_pair(make_pair(lo, hi, lohi, hi, lo, hilo));
        push_pair(make_pair(lohi, lo, hi, hilo, lohi, hi));
        push_pair(make_pair(lo, lohi, hi, lo, hilo, pt(0, 0)));
    endtask

    // Shared vertex counts other than two give a plain count only.
    task automatic test_shared_counts();
        tef_pkg::tef_pt_t p, q, r, s;
        p = pt(1, 2);
        q = pt(5, -3);
        r = pt(-4, 7);
        s = pt(9, 9);
        push_pair(make_pair(p, q, r, pt(0, 1), pt(2, 2), s));
        push_pair(make_pair(p, q, r, p, s, pt(3, 3)));
        push_pair(make_pair(p, q, r, r, p, q));
        push_pair(make_pair(p, p, q, p, p, r));
        push_pair(make_pair(p, p, p, p, p, p));
    endtask

    // Convex quads, and overlapping triangles on one side of ab.
    task automatic test_flip_geometry();
        tef_pkg::tef_pt_t a, b;
        a = pt(0, 0);
        b = pt(10, 10);
        push_pair(make_pair(a, b, pt(0, 10), b, pt(10, 0), a));
        push_pair(make_pair(pt(0, 10), a, b, pt(10, 0), a, b));
        push_pair(make_pair(a, b, pt(0, 10), a, b, pt(2, 12)));
        push_pair(make_pair(a, b, pt(-1, 3), a, b, pt(30, 2)));
    endtask

    // Degenerate cases: a lone vertex on line ab, a repeated point making a
    // equal b, and line cd passing through a shared vertex.
    task automatic test_degenerate();
        tef_pkg::tef_pt_t a, b;
        a = pt(0, 0);
        b = pt(8, 8);
        push_pair(make_pair(a, b, pt(4, 4), a, b, pt(8, 0)));
        push_pair(make_pair(a, a, pt(3, 1), a, pt(5, 5), pt(-2, 6)));
        push_pair(make_pair(a, b, pt(-4, 4), a, b, pt(4, -4)));
    endtask

    // The square of side four gives determinants of magnitude 16, so the
    // verdict turns from flippable to degenerate between tolerance 15 and 16.
    task automatic test_tolerance_edge();
        tef_pkg::tef_item_t sq;
        sq = make_pair(pt(0, 0), pt(4, 4), pt(0, 4), pt(4, 4), pt(0, 0), pt(4, 0));
        set_tolerance(tef_pkg::TOL_WIDTH'(15));
        push_pair(sq);
        set_tolerance(tef_pkg::TOL_WIDTH'(16));
        push_pair(sq);
        set_tolerance(TOL_MAX);
        push_pair(sq);
    endtask

    // Random pairs over several tolerance settings. Most pairs share an edge
    // on purpose so that the determinant path is exercised; the rest are
    // unrelated points, tight grids and repeated points.
    task automatic test_random_stream(int unsigned per_phase);
        tef_pkg::tef_pt_t              a, b, c, d, p;
        tri_pts_t                      ta, tb;
        int unsigned                   r, mode;
        logic [tef_pkg::TOL_WIDTH-1:0] tol_pick[6];
        tol_pick[0] = '0;
        tol_pick[1] = TOL_MAX;
        tol_pick[2] = tef_pkg::TOL_WIDTH'($urandom_range(1, 300));
        tol_pick[3] = tef_pkg::TOL_WIDTH'($urandom_range(0, int'(TOL_MAX)));
        tol_pick[4] = tef_pkg::TOL_WIDTH'(1);
        tol_pick[5] = tef_pkg::TOL_WIDTH'($urandom_range(1000, 100000));
        for (int ph = 0; ph < 6; ph++)
        begin
            set_tolerance(tol_pick[ph]);
            for (int n = 0; n < per_phase; n++)
            begin
                // Blocks of 50 beats; about one in four runs without any idling.
                if (n % 50 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                mode = $urandom_range(0, 3);
                if (r < 70)
                begin
                    a = rand_pt(mode);
                    b = rand_pt(mode);
                    c = rand_pt(mode);
                    d = rand_pt(mode);
                    ta = shuffled({c, b, a});
                    tb = shuffled({d, b, a});
                end
                else if (r < 82)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        ta[k] = rand_pt($urandom_range(0, 4));
                        tb[k] = rand_pt($urandom_range(0, 4));
                    end
                end
                else if (r < 92)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        ta[k] = rand_pt(4);
                        tb[k] = rand_pt(4);
                    end
                end
                else
                begin
                    p = rand_pt(mode);
                    for (int k = 0; k < 3; k++)
                    begin
                        ta[k] = $urandom_range(0, 1) ? p : rand_pt(1);
                        tb[k] = $urandom_range(0, 1) ? p : rand_pt(1);
                    end
                end
                push_pair(make_pair(ta[0], ta[1], ta[2], tb[0], tb[1], tb[2]));
            end
        end
        quiet = 1'b0;
    endtask

    // Receiver side: result_stall goes high for random stretches.
    initial
    begin
        int unsigned hold;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            hold = pick_gap();
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                result_stall <= 1'b0;
            end
            repeat ($urandom_range(0, 4)) @(posedge clk);
        end
    end

    // Every result beat is checked against the oldest predicted verdict.
    // The cycle counter here also ends a run that hangs.
    always @(posedge clk)
    begin
        tef_pkg::tef_result_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_triangle_edge_flip_test_core: errors");
            $finish;
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result beat with no verdict pending: %0d %0d %0d",
                       result.shared_pairs, result.flippable, result.degenerate);
                mismatches = mismatches + 1;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (result.shared_pairs !== want.shared_pairs)
                begin
                    $error("shared_pairs: expected %0d, got %0d",
                           want.shared_pairs, result.shared_pairs);
                    mismatches = mismatches + 1;
                end
                if (result.flippable !== want.flippable)
                begin
                    $error("flippable: expected %0d, got %0d",
                           want.flippable, result.flippable);
                    mismatches = mismatches + 1;
                end
                if (result.degenerate !== want.degenerate)
                begin
                    $error("degenerate: expected %0d, got %0d",
                           want.degenerate, result.degenerate);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // Test sequence: reset, directed tests at the reset tolerance, the
    // tolerance boundary, then the random stream, then drain and report.
    initial
    begin
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        tol_now     = '0;
        mismatches  = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_shared_counts();
        test_flip_geometry();
        test_degenerate();
        test_tolerance_edge();
        test_random_stream(290);

        drain();
        if (mismatches == 0)
            $display("tb_triangle_edge_flip_test_core: clean");
        else
            $display("tb_triangle_edge_flip_test_core: errors");
        $finish;
    end

endmodule
